### hw/rtl/mhc_pkg.sv
// ----------------------------------------------------------------------------
// mhc_pkg
// shared widths, constants, fsm encoding, command struct and the cordic
// arctangent table for the magnetometer heading block
// ----------------------------------------------------------------------------
package mhc_pkg;

  localparam int XY_W    = 20;  // cordic x/y, covers 32768 * sqrt(2) * gain
  localparam int ACC_W   = 26;  // angle accumulator, 2^-16 degree units
  localparam int STEP_W  = 5;   // iteration index, table has 24 entries
  localparam int TAB_LEN = 24;
  localparam int HEAD_W  = 16;
  localparam int RND_W   = 17;  // rounded heading before the full turn wrap

  localparam logic signed [ACC_W-1:0] DEG180_FIX = 26'sd11796480;
  localparam logic signed [ACC_W-1:0] DEG360_FIX = 26'sd23592960;
  localparam logic [ACC_W-1:0]        RND_HALF   = 26'd256;
  localparam logic [RND_W-1:0]        FULL_TURN  = 17'd46080;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROT  = 5'b00010,
    S_WRAP = 5'b00100,
    S_RND  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  typedef struct packed {
    logic              load;     // capture a sample and pre-rotate
    logic              step;     // one cordic micro-rotation
    logic [STEP_W-1:0] idx;      // iteration index for the step
    logic              wrap;     // fold a negative angle by a full turn
    logic              round;    // round to 1/128 degree, update held values
    logic              publish;  // copy held values to the output register
  } dp_cmd_t;

  // atan(2^-i) in degrees times 65536, rounded to nearest
  function automatic logic signed [ACC_W-1:0] atan_tab(input logic [STEP_W-1:0] i);
    logic signed [ACC_W-1:0] v;
    case (i)
      5'd0:    v = 26'sd2949120;
      5'd1:    v = 26'sd1740967;
      5'd2:    v = 26'sd919879;
      5'd3:    v = 26'sd466945;
      5'd4:    v = 26'sd234379;
      5'd5:    v = 26'sd117304;
      5'd6:    v = 26'sd58666;
      5'd7:    v = 26'sd29335;
      5'd8:    v = 26'sd14668;
      5'd9:    v = 26'sd7334;
      5'd10:   v = 26'sd3667;
      5'd11:   v = 26'sd1833;
      5'd12:   v = 26'sd917;
      5'd13:   v = 26'sd458;
      5'd14:   v = 26'sd229;
      5'd15:   v = 26'sd115;
      5'd16:   v = 26'sd57;
      5'd17:   v = 26'sd29;
      5'd18:   v = 26'sd14;
      5'd19:   v = 26'sd7;
      5'd20:   v = 26'sd4;
      5'd21:   v = 26'sd2;
      5'd22:   v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/mhc_ctrl.sv
// ----------------------------------------------------------------------------
// mhc_ctrl
// sequencer for the heading block: input handshake, cordic iteration count
// and output register valid
// ----------------------------------------------------------------------------
module mhc_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_read_ok,
  output logic             out_valid,
  input  logic             out_stall,
  output mhc_pkg::dp_cmd_t cmd
);

  localparam logic [mhc_pkg::STEP_W-1:0] LAST_STEP = mhc_pkg::STEP_W'(CORDIC_STEPS - 1);

  mhc_pkg::state_t           state_r, state_nxt;
  logic [mhc_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != mhc_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.idx       = step_r;
    case (state_r)
      mhc_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = in_read_ok ? mhc_pkg::S_ROT : mhc_pkg::S_DONE;
        end
      end
      mhc_pkg::S_ROT: begin
        cmd.step = 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = mhc_pkg::S_WRAP;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      mhc_pkg::S_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = mhc_pkg::S_RND;
      end
      mhc_pkg::S_RND: begin
        cmd.round = 1'b1;
        state_nxt = mhc_pkg::S_DONE;
      end
      mhc_pkg::S_DONE: begin
        if (out_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mhc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mhc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhc_pkg::S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // an accepted item always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != mhc_pkg::S_IDLE)
    else $error("accepted transfer did not start work");

  // iteration index never runs past the configured step count
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mhc_pkg::S_ROT |-> step_r <= LAST_STEP)
    else $error("cordic step index out of range");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !(out_valid_r && out_stall))
    else $error("output register overwritten while stalled");

  // a published result shows as valid in the next cycle
  a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid_r)
    else $error("published result not valid");
`endif

endmodule

### hw/rtl/mhc_dp.sv
// ----------------------------------------------------------------------------
// mhc_dp
// datapath: sample capture, iterative cordic vectoring, angle fold and
// rounding, held values and the output register
// ----------------------------------------------------------------------------
module mhc_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mhc_pkg::dp_cmd_t     cmd,
  input  logic                 in_read_ok,
  input  logic [7:0]           in_x_low_byte,
  input  logic [7:0]           in_x_high_byte,
  input  logic [7:0]           in_y_low_byte,
  input  logic [7:0]           in_y_high_byte,
  input  logic [7:0]           in_z_low_byte,
  input  logic [7:0]           in_z_high_byte,
  input  logic [31:0]          in_tick_ms,
  output logic signed [15:0]   out_field_x,
  output logic signed [15:0]   out_field_y,
  output logic signed [15:0]   out_field_z,
  output logic [15:0]          out_heading,
  output logic [31:0]          out_sample_time,
  output logic                 out_updated
);

  localparam int XW = mhc_pkg::XY_W;
  localparam int AW = mhc_pkg::ACC_W;

  // captured sample
  logic [15:0]             raw_x_r, raw_y_r, raw_z_r;
  logic [31:0]             tick_r;
  logic                    ok_r, zero_r;
  // cordic state
  logic signed [XW-1:0]    cx_r, cy_r;
  logic signed [AW-1:0]    acc_r;
  // held values, reset to zero
  logic [15:0]             held_x_r, held_y_r, held_z_r, held_heading_r;
  logic [31:0]             held_time_r;
  // output register
  logic [15:0]             ox_r, oy_r, oz_r, oh_r;
  logic [31:0]             ot_r;
  logic                    ou_r;

  logic [15:0]             in_x, in_y;
  logic signed [XW-1:0]    sx, sy;
  logic signed [XW-1:0]    dx, dy;
  logic signed [AW-1:0]    ang;
  logic [AW-1:0]           rsum;
  logic [mhc_pkg::RND_W-1:0] rnd;
  logic [mhc_pkg::RND_W-1:0] rnd_wr;

  assign in_x = {in_x_high_byte, in_x_low_byte};
  assign in_y = {in_y_high_byte, in_y_low_byte};
  assign sx   = XW'(signed'(in_x));
  assign sy   = XW'(signed'(in_y));

  assign dx  = cy_r >>> cmd.idx;
  assign dy  = cx_r >>> cmd.idx;
  assign ang = mhc_pkg::atan_tab(cmd.idx);

  // half up rounding to 1/128 degree, then the full turn wrap
  assign rsum   = acc_r + mhc_pkg::RND_HALF;
  assign rnd    = rsum[AW-1:9];
  assign rnd_wr = (rnd >= mhc_pkg::FULL_TURN) ? (rnd - mhc_pkg::FULL_TURN) : rnd;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_x_r <= in_x;
      raw_y_r <= in_y;
      raw_z_r <= {in_z_high_byte, in_z_low_byte};
      tick_r  <= in_tick_ms;
      ok_r    <= in_read_ok;
      zero_r  <= (in_x == 16'd0) && (in_y == 16'd0);
      // pre-rotate into the right half plane
      if (in_x[15]) begin
        cx_r  <= -sx;
        cy_r  <= -sy;
        acc_r <= mhc_pkg::DEG180_FIX;
      end else begin
        cx_r  <= sx;
        cy_r  <= sy;
        acc_r <= '0;
      end
    end else if (cmd.step) begin
      if (!cy_r[XW-1]) begin
        cx_r  <= cx_r + dx;
        cy_r  <= cy_r - dy;
        acc_r <= acc_r + ang;
      end else begin
        cx_r  <= cx_r - dx;
        cy_r  <= cy_r + dy;
        acc_r <= acc_r - ang;
      end
    end else if (cmd.wrap) begin
      if (acc_r[AW-1]) begin
        acc_r <= acc_r + mhc_pkg::DEG360_FIX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r       <= '0;
      held_y_r       <= '0;
      held_z_r       <= '0;
      held_heading_r <= '0;
      held_time_r    <= '0;
    end else if (cmd.round) begin
      held_x_r       <= raw_x_r;
      held_y_r       <= raw_y_r;
      held_z_r       <= raw_z_r;
      held_heading_r <= zero_r ? 16'd0 : rnd_wr[mhc_pkg::HEAD_W-1:0];
      held_time_r    <= tick_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      ox_r <= held_x_r;
      oy_r <= held_y_r;
      oz_r <= held_z_r;
      oh_r <= held_heading_r;
      ot_r <= held_time_r;
      ou_r <= ok_r;
    end
  end

  assign out_field_x     = signed'(ox_r);
  assign out_field_y     = signed'(oy_r);
  assign out_field_z     = signed'(oz_r);
  assign out_heading     = oh_r;
  assign out_sample_time = ot_r;
  assign out_updated     = ou_r;

endmodule

### hw/rtl/magnetometer_heading_calc_core.sv
// ----------------------------------------------------------------------------
// magnetometer_heading_calc_core
// packs a magnetometer sample into signed x/y/z and computes the flat
// heading atan2(y, x) in 1/128 degree by iterative cordic
// ----------------------------------------------------------------------------
//
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------
// in_      | in_valid / in_stall  | read_ok, x/y/z low and high bytes, tick_ms
// out_     | out_valid / out_stall| field_x/y/z, heading, sample_time, updated
//
// a good read goes from transfer to result through a capture state, one
// cordic micro-rotation per cycle on a single shared add/shift unit, an
// angle fold state, a rounding state and the publish
// a failed read goes through capture, then the held values are published
// the next input transfer is taken once the previous result sits in the
// output register, so a result waiting on out_stall does not block intake
// rst_n is synchronous, active low, and clears the held values to zero
//
module magnetometer_heading_calc_core #(
  parameter int CORDIC_STEPS = 16   // 8 to 24
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_read_ok,
  input  logic [7:0]         in_x_low_byte,
  input  logic [7:0]         in_x_high_byte,
  input  logic [7:0]         in_y_low_byte,
  input  logic [7:0]         in_y_high_byte,
  input  logic [7:0]         in_z_low_byte,
  input  logic [7:0]         in_z_high_byte,
  input  logic [31:0]        in_tick_ms,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_field_x,
  output logic signed [15:0] out_field_y,
  output logic signed [15:0] out_field_z,
  output logic [15:0]        out_heading,
  output logic [31:0]        out_sample_time,
  output logic               out_updated
);

  // commands from the sequencer to the datapath
  mhc_pkg::dp_cmd_t cmd;

  // sequencer: handshake, step count, output valid
  mhc_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_read_ok (in_read_ok),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd)
  );

  // datapath: capture, cordic, rounding, held values, output register
  mhc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_read_ok      (in_read_ok),
    .in_x_low_byte   (in_x_low_byte),
    .in_x_high_byte  (in_x_high_byte),
    .in_y_low_byte   (in_y_low_byte),
    .in_y_high_byte  (in_y_high_byte),
    .in_z_low_byte   (in_z_low_byte),
    .in_z_high_byte  (in_z_high_byte),
    .in_tick_ms      (in_tick_ms),
    .out_field_x     (out_field_x),
    .out_field_y     (out_field_y),
    .out_field_z     (out_field_z),
    .out_heading     (out_heading),
    .out_sample_time (out_sample_time),
    .out_updated     (out_updated)
  );

endmodule
